// ----- src/hmc_pkg.sv -----
// Shared constants, types and helper functions for the Hamming (63,57) chunk encoder.
package hmc_pkg;

  localparam int unsigned ChunkBytes = 57;
  localparam int unsigned CodeBytes  = 63;
  localparam int unsigned WordBits   = 63;
  localparam int unsigned WordCount  = 8;

  localparam int unsigned AddrW    = $clog2(ChunkBytes);
  localparam int unsigned PosW     = $clog2(WordBits + 1);
  localparam int unsigned BitIdxW  = $clog2(ChunkBytes * 8);
  localparam int unsigned WordIdxW = $clog2(WordCount);
  localparam int unsigned ByteCntW = $clog2(CodeBytes);

  typedef enum logic [1:0] {
    StCollect,
    StFill,
    StEmit
  } state_e;

  // Per-cycle control from the sequencer to the shared bit unit.
  typedef struct packed {
    logic            fill;
    logic            emit;
    logic [PosW-1:0] pos;
    logic            data_bit;
  } ctl_t;

  // True when a 1-based codeword position holds a parity bit.
  function automatic logic is_pow2(logic [PosW-1:0] p);
    return (p & (p - PosW'(1))) == '0;
  endfunction

endpackage

// ----- src/hmc_store.sv -----
// Chunk store: 57 data bytes, one write port and one registered read port.
module hmc_store (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [hmc_pkg::AddrW-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  input  logic [hmc_pkg::AddrW-1:0] rd_addr_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0] mem_q [hmc_pkg::ChunkBytes];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // Addresses past the chunk only occur once the last data bit is used.
    if (rd_addr_i < hmc_pkg::AddrW'(hmc_pkg::ChunkBytes)) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/hmc_unit.sv -----
// Shared bit-serial unit: builds one codeword with its parity, then shifts it out as bytes.
module hmc_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hmc_pkg::ctl_t ctl_i,
  output logic [7:0]    code_byte_o,
  output logic          chunk_end_o,
  output logic          strobe_o
);

  localparam int unsigned ParW = hmc_pkg::PosW;

  logic [hmc_pkg::WordBits-1:0] cw_q, cw_d;
  logic [ParW-1:0]              par_q, par_d;
  logic [6:0]                   acc_q, acc_d;
  logic [2:0]                   nbit_q, nbit_d;
  logic [hmc_pkg::ByteCntW-1:0] nbyte_q, nbyte_d;
  logic [7:0]                   byte_q, byte_d;
  logic                         end_q, end_d;
  logic                         strobe_q, strobe_d;
  logic                         pow2, fill_bit, out_bit;

  always_comb begin
    pow2     = hmc_pkg::is_pow2(ctl_i.pos);
    fill_bit = pow2 ? 1'b0 : ctl_i.data_bit;
    // The position index is one-hot at a parity slot, so this picks its parity bit.
    out_bit  = pow2 ? ^(par_q & ctl_i.pos) : cw_q[0];

    cw_d     = cw_q;
    par_d    = par_q;
    acc_d    = acc_q;
    nbit_d   = nbit_q;
    nbyte_d  = nbyte_q;
    byte_d   = byte_q;
    end_d    = end_q;
    strobe_d = 1'b0;

    if (ctl_i.fill) begin
      cw_d  = {fill_bit, cw_q[hmc_pkg::WordBits-1:1]};
      par_d = ((ctl_i.pos == ParW'(1)) ? '0 : par_q) ^ (fill_bit ? ctl_i.pos : '0);
    end

    if (ctl_i.emit) begin
      cw_d   = {1'b0, cw_q[hmc_pkg::WordBits-1:1]};
      acc_d  = {acc_q[5:0], out_bit};
      nbit_d = nbit_q + 3'd1;
      if (nbit_q == 3'd7) begin
        strobe_d = 1'b1;
        byte_d   = {acc_q, out_bit};
        end_d    = (nbyte_q == hmc_pkg::ByteCntW'(hmc_pkg::CodeBytes - 1));
        nbyte_d  = end_d ? '0 : nbyte_q + hmc_pkg::ByteCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbit_q   <= '0;
      nbyte_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      nbit_q   <= nbit_d;
      nbyte_q  <= nbyte_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q   <= cw_d;
    par_q  <= par_d;
    acc_q  <= acc_d;
    byte_q <= byte_d;
    end_q  <= end_d;
  end

  assign code_byte_o = byte_q;
  assign chunk_end_o = end_q;
  assign strobe_o    = strobe_q;

endmodule

// ----- src/hamming_63_57_chunk_encoder.sv -----
// Top level of the Hamming (63,57) chunk encoder: sequencer, chunk store and bit unit.
//
// The block takes one data byte per cycle while busy_o is low, and a word is accepted at each
// rising edge with start_i high and busy_o low. After the 57th byte of a chunk it raises busy_o
// and encodes the 456 collected bits as eight 63-bit Hamming words, parity at positions 1, 2, 4,
// 8, 16 and 32, sending 63 code words out MSB first. Each output word is held on code_byte_o
// for exactly one cycle with strobe_o high, and chunk_end_o marks the 63rd; the receiver cannot
// stall, so it must take every strobed word. Encoding runs through one shared bit-serial unit,
// which handles each codeword in two passes, one to gather the data bits and parity and one to
// shift the word out, so a chunk keeps the block busy through both passes of all eight codewords.
// Bytes of an unfinished chunk stay held until the chunk completes or reset discards them.
module hamming_63_57_chunk_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] data_byte_i,
  output logic       busy_o,
  output logic [7:0] code_byte_o,
  output logic       chunk_end_o,
  output logic       strobe_o
);

  localparam int unsigned AddrW    = hmc_pkg::AddrW;
  localparam int unsigned PosW     = hmc_pkg::PosW;
  localparam int unsigned BitIdxW  = hmc_pkg::BitIdxW;
  localparam int unsigned WordIdxW = hmc_pkg::WordIdxW;

  hmc_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]    held_q, held_d;   // bytes collected of the current chunk
  logic [PosW-1:0]     pos_q, pos_d;     // 1-based position within the codeword
  logic [WordIdxW-1:0] word_q, word_d;   // codeword being worked on
  logic [BitIdxW-1:0]  idx_q, idx_d;     // next data bit of the chunk
  logic                accept, last_pos;
  logic [7:0]          rd_data;
  hmc_pkg::ctl_t       ctl;

  assign accept   = start_i && !busy_o;
  assign last_pos = (pos_q == PosW'(hmc_pkg::WordBits));

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    pos_d   = pos_q;
    word_d  = word_q;
    idx_d   = idx_q;
    case (state_q)
      hmc_pkg::StCollect: begin
        pos_d  = PosW'(1);
        word_d = '0;
        idx_d  = '0;
        if (accept) begin
          if (held_q == AddrW'(hmc_pkg::ChunkBytes - 1)) begin
            held_d  = '0;
            state_d = hmc_pkg::StFill;
          end else begin
            held_d = held_q + AddrW'(1);
          end
        end
      end
      hmc_pkg::StFill: begin
        // Data bits are consumed only at positions that are not parity slots.
        if (!hmc_pkg::is_pow2(pos_q)) begin
          idx_d = idx_q + BitIdxW'(1);
        end
        if (last_pos) begin
          pos_d   = PosW'(1);
          state_d = hmc_pkg::StEmit;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
      hmc_pkg::StEmit: begin
        if (last_pos) begin
          pos_d = PosW'(1);
          if (word_q == WordIdxW'(hmc_pkg::WordCount - 1)) begin
            state_d = hmc_pkg::StCollect;
          end else begin
            word_d  = word_q + WordIdxW'(1);
            state_d = hmc_pkg::StFill;
          end
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
      default: begin
        state_d = hmc_pkg::StCollect;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy_o       = 1'b1;
    ctl.fill     = 1'b0;
    ctl.emit     = 1'b0;
    ctl.pos      = pos_q;
    // Bytes are read MSB first, so bit 0 of the index selects bit 7 of the byte.
    ctl.data_bit = rd_data[~idx_q[2:0]];
    case (state_q)
      hmc_pkg::StCollect: busy_o   = 1'b0;
      hmc_pkg::StFill:    ctl.fill = 1'b1;
      hmc_pkg::StEmit:    ctl.emit = 1'b1;
      default:            busy_o   = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmc_pkg::StCollect;
      held_q  <= '0;
      pos_q   <= PosW'(1);
      word_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      pos_q   <= pos_d;
      word_q  <= word_d;
      idx_q   <= idx_d;
    end
  end

  // The read address follows the next bit index, so the registered read data always holds
  // the byte of the current bit.
  hmc_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (held_q),
    .wr_data_i (data_byte_i),
    .rd_addr_i (idx_d[BitIdxW-1:3]),
    .rd_data_o (rd_data)
  );

  hmc_unit u_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .code_byte_o (code_byte_o),
    .chunk_end_o (chunk_end_o),
    .strobe_o    (strobe_o)
  );

  // A word only leaves while a chunk is being encoded.
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o |-> $past(busy_o))
    else $error("output word strobed outside an encoding pass");

  // The 57th byte of a chunk always starts an encoding pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && held_q == AddrW'(hmc_pkg::ChunkBytes - 1)) |=> busy_o)
    else $error("completed chunk did not start encoding");

  // The last word of a chunk comes with the strobe, and the block is free again by then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && chunk_end_o) |-> !busy_o)
    else $error("chunk end flagged while encoding still runs");

  // Every fill pass ends on a whole codeword's worth of data bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hmc_pkg::StFill && last_pos) |->
      (idx_q == BitIdxW'(hmc_pkg::ChunkBytes * 8 / hmc_pkg::WordCount) *
                (BitIdxW'(word_q) + BitIdxW'(1)) - BitIdxW'(1)))
    else $error("data bit index out of step with the codeword count");

endmodule
